### hdl/gtpc_pkg.sv
`default_nettype none

package gtpc_pkg;

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    CFG_GRID_TILES_X    = 2'd0,
    CFG_GRID_TILES_Y    = 2'd1,
    CFG_TILES_PER_PATCH = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_idx_e;

  // patch classification codes
  typedef enum logic [1:0] {
    PC_CLEAR = 2'd0,
    PC_HIT   = 2'd1,
    PC_MIXED = 2'd2
  } patch_class_e;

  localparam int unsigned CFG_W   = 7;
  localparam int unsigned PATCH_W = 3;
  localparam int unsigned COORD_W = 6;

  // reset values of the registers
  localparam logic [CFG_W-1:0]   GRID_X_RST = 7'd1;
  localparam logic [CFG_W-1:0]   GRID_Y_RST = 7'd1;
  localparam logic [PATCH_W-1:0] PATCH_RST  = 3'd7;

  // per patch column flags carried along the flag chain
  typedef struct packed {
    logic valid;
    logic all_clear;
    logic all_hit;
  } flag_t;

  // one result item
  typedef struct packed {
    logic [COORD_W-1:0] tile_col;
    logic [COORD_W-1:0] tile_row;
    logic               tile_hit;
    logic               patch_valid;
    logic [COORD_W-1:0] patch_col;
    logic [COORD_W-1:0] patch_row;
    patch_class_e       patch_class;
    logic               grid_done;
  } res_t;

endpackage

`default_nettype wire

### hdl/gtpc_lb_cell.sv
`default_nettype none

// one vertex bit of the line buffer chain
module gtpc_lb_cell (
  input  wire logic clk_i,
  input  wire logic shift_i,
  input  wire logic load_sel_i,
  input  wire logic ins_i,
  input  wire logic prev_i,
  output logic      q_o
);

  logic bit_q;
  logic bit_d;

  // the insertion point takes the new vertex, every other cell its neighbor
  always_comb begin
    bit_d = load_sel_i ? ins_i : prev_i;
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      bit_q <= bit_d;
    end
  end

  assign q_o = bit_q;

endmodule

`default_nettype wire

### hdl/gtpc_flag_cell.sv
`default_nettype none

// one entry of the patch column flag chain
module gtpc_flag_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           clear_i,
  input  wire logic           shift_i,
  input  wire logic           load_sel_i,
  input  wire gtpc_pkg::flag_t ins_i,
  input  wire gtpc_pkg::flag_t prev_i,
  output gtpc_pkg::flag_t     q_o
);

  logic            valid_q;
  logic            valid_d;
  logic            clr_q;
  logic            hit_q;
  gtpc_pkg::flag_t ent_d;

  // pick the entry this cell takes on a shift
  always_comb begin
    ent_d   = load_sel_i ? ins_i : prev_i;
    valid_d = valid_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (shift_i) begin
      valid_d = ent_d.valid;
    end
  end

  // valid bit, cleared at once on a new grid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // flag payload
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      clr_q <= ent_d.all_clear;
      hit_q <= ent_d.all_hit;
    end
  end

  assign q_o = '{valid: valid_q, all_clear: clr_q, all_hit: hit_q};

endmodule

`default_nettype wire

### hdl/grid_tile_patch_classifier.sv
`default_nettype none

// channel   | signals                                         | direction
// ----------+-------------------------------------------------+----------
// in        | in_valid_i, in_stall_o, vertex_hit_i            | in
// out       | out_valid_o, out_stall_i, tile_*_o, patch_*_o,  | out
//           | grid_done_o                                     |
// cfg       | cfg_we_i, cfg_idx_i, cfg_wdata_i                | in
//
// one vertex is taken every cycle while in_stall_o is low; its tile result is registered
// the line buffer is a chain of cells shifted per vertex, the patch flags one shifted per
// finished patch column, so each item does one neighbor-to-neighbor move and nothing iterates
// an output register plus a skid register decouple the two channels;
// in_stall_o comes from the skid register only
// reset clears the counters and the flag valid bits at once, no clearing pass
// a register write (not to CFG_UNUSED) restarts the scan at the first vertex of a new grid
module grid_tile_patch_classifier #(
  parameter int unsigned MAX_TILES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [6:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        vertex_hit_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             tile_valid_o,
  output logic [5:0]       tile_col_o,
  output logic [5:0]       tile_row_o,
  output logic             tile_hit_o,
  output logic             patch_valid_o,
  output logic [5:0]       patch_col_o,
  output logic [5:0]       patch_row_o,
  output logic [1:0]       patch_class_o,
  output logic             grid_done_o
);

  localparam int unsigned CW   = $clog2(MAX_TILES + 1);
  localparam int unsigned LB_N = MAX_TILES + 1;
  localparam int unsigned FL_N = MAX_TILES;

  // configuration registers
  logic [gtpc_pkg::CFG_W-1:0]   cfg_x_q;
  logic [gtpc_pkg::CFG_W-1:0]   cfg_y_q;
  logic [gtpc_pkg::PATCH_W-1:0] cfg_t_q;
  logic                         cfg_hit;

  // scan state
  logic [CW-1:0]                col_q, col_d;
  logic [CW-1:0]                row_q, row_d;
  logic [gtpc_pkg::PATCH_W-1:0] icol_q, icol_d;
  logic [gtpc_pkg::PATCH_W-1:0] irow_q, irow_d;
  logic [CW-1:0]                pc_q, pc_d;
  logic [gtpc_pkg::COORD_W-1:0] prc_q, prc_d;
  logic [CW-1:0]                npc_q, npc_d;
  logic                         left_q;
  logic                         tail2_q;
  logic                         acc_clr_q;
  logic                         acc_hit_q;

  // derived per item values
  logic [CW-1:0]                nx;
  logic [CW-1:0]                ny;
  logic [gtpc_pkg::PATCH_W-1:0] t_m1;
  logic                         in_acc;
  logic                         is_tile;
  logic                         last_col;
  logic                         last_row;
  logic                         col_end;
  logic                         row_end;
  logic                         hit;
  logic                         base_clr;
  logic                         base_hit;
  logic                         new_clr;
  logic                         new_hit;
  logic                         restart;
  logic                         fl_shift;
  gtpc_pkg::flag_t              fl_ins;
  gtpc_pkg::flag_t              head;
  gtpc_pkg::res_t               res;

  // cell chains
  logic                         lb_bit [LB_N];
  gtpc_pkg::flag_t              fl_ent [FL_N];

  // output register and skid
  gtpc_pkg::res_t               out_q, skid_q;
  logic                         out_vld_q, skid_vld_q;
  logic                         take;
  logic                         push;

  // clamped grid size and patch side
  always_comb begin
    if (cfg_x_q == '0) begin
      nx = CW'(1);
    end else if (int'(cfg_x_q) > int'(MAX_TILES)) begin
      nx = CW'(MAX_TILES);
    end else begin
      nx = CW'(cfg_x_q);
    end
    if (cfg_y_q == '0) begin
      ny = CW'(1);
    end else if (int'(cfg_y_q) > int'(MAX_TILES)) begin
      ny = CW'(MAX_TILES);
    end else begin
      ny = CW'(cfg_y_q);
    end
    t_m1 = (cfg_t_q == '0) ? '0 : cfg_t_q - 3'd1;
  end

  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign cfg_hit    = cfg_we_i & (cfg_idx_i != gtpc_pkg::CFG_UNUSED);

  // line buffer chain: new vertex enters nx+1 cells before the tail
  for (genvar k = 0; k < LB_N; k++) begin : g_lb
    gtpc_lb_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (in_acc),
      .load_sel_i (nx == CW'(LB_N - 1 - k)),
      .ins_i      (vertex_hit_i),
      .prev_i     ((k == 0) ? 1'b0 : lb_bit[(k == 0) ? 0 : k - 1]),
      .q_o        (lb_bit[k])
    );
  end

  // flag chain: an entry comes back to the head one row later
  for (genvar k = 0; k < FL_N; k++) begin : g_fl
    gtpc_flag_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clear_i    (restart),
      .shift_i    (fl_shift),
      .load_sel_i (npc_q == CW'(FL_N - k)),
      .ins_i      (fl_ins),
      .prev_i     ((k == 0) ? gtpc_pkg::flag_t'('0) : fl_ent[(k == 0) ? 0 : k - 1]),
      .q_o        (fl_ent[k])
    );
  end

  assign head = fl_ent[FL_N-1];

  // tile hit and patch flag update
  always_comb begin
    is_tile  = (row_q != '0) && (col_q != '0);
    last_col = (col_q == nx);
    last_row = (row_q == ny);
    col_end  = (icol_q == t_m1) || last_col;
    row_end  = (irow_q == t_m1) || last_row;
    hit      = tail2_q | lb_bit[LB_N-1] | left_q | vertex_hit_i;
    if (icol_q == '0) begin
      base_clr = head.valid ? head.all_clear : 1'b1;
      base_hit = head.valid ? head.all_hit : 1'b1;
    end else begin
      base_clr = acc_clr_q;
      base_hit = acc_hit_q;
    end
    new_clr  = base_clr & ~hit;
    new_hit  = base_hit & hit;
    fl_shift = in_acc & is_tile & col_end;
    fl_ins   = '{valid: ~row_end, all_clear: new_clr, all_hit: new_hit};
    restart  = cfg_hit | (in_acc & last_col & last_row);
  end

  // result item
  always_comb begin
    res             = '0;
    res.tile_col    = gtpc_pkg::COORD_W'(col_q - CW'(1));
    res.tile_row    = gtpc_pkg::COORD_W'(row_q - CW'(1));
    res.tile_hit    = hit;
    res.patch_valid = col_end & row_end;
    res.patch_class = gtpc_pkg::PC_CLEAR;
    if (col_end && row_end) begin
      res.patch_col = gtpc_pkg::COORD_W'(pc_q);
      res.patch_row = prc_q;
      if (new_hit) begin
        res.patch_class = gtpc_pkg::PC_HIT;
      end else if (new_clr) begin
        res.patch_class = gtpc_pkg::PC_CLEAR;
      end else begin
        res.patch_class = gtpc_pkg::PC_MIXED;
      end
    end
    res.grid_done   = last_col & last_row;
  end

  // scan counters
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    icol_d = icol_q;
    irow_d = irow_q;
    pc_d   = pc_q;
    prc_d  = prc_q;
    npc_d  = npc_q;
    if (cfg_hit) begin
      col_d  = '0;
      row_d  = '0;
      icol_d = '0;
      irow_d = '0;
      pc_d   = '0;
      prc_d  = '0;
      npc_d  = '0;
    end else if (in_acc) begin
      // count patch columns while the first vertex row goes by
      if ((row_q == '0) && (col_q != '0) && col_end) begin
        npc_d = npc_q + CW'(1);
      end
      if (last_col) begin
        col_d  = '0;
        icol_d = '0;
        pc_d   = '0;
        if (row_q != '0) begin
          if (irow_q >= t_m1) begin
            irow_d = '0;
            prc_d  = prc_q + 6'd1;
          end else begin
            irow_d = irow_q + 3'd1;
          end
        end
        if (last_row) begin
          row_d  = '0;
          irow_d = '0;
          prc_d  = '0;
          npc_d  = '0;
        end else begin
          row_d = row_q + CW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
        if (col_q != '0) begin
          if (col_end) begin
            icol_d = '0;
            pc_d   = pc_q + CW'(1);
          end else begin
            icol_d = icol_q + 3'd1;
          end
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_x_q <= gtpc_pkg::GRID_X_RST;
      cfg_y_q <= gtpc_pkg::GRID_Y_RST;
      cfg_t_q <= gtpc_pkg::PATCH_RST;
      col_q   <= '0;
      row_q   <= '0;
      icol_q  <= '0;
      irow_q  <= '0;
      pc_q    <= '0;
      prc_q   <= '0;
      npc_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gtpc_pkg::CFG_GRID_TILES_X:    cfg_x_q <= cfg_wdata_i;
          gtpc_pkg::CFG_GRID_TILES_Y:    cfg_y_q <= cfg_wdata_i;
          gtpc_pkg::CFG_TILES_PER_PATCH: cfg_t_q <= cfg_wdata_i[2:0];
          default: ;
        endcase
      end
      col_q  <= col_d;
      row_q  <= row_d;
      icol_q <= icol_d;
      irow_q <= irow_d;
      pc_q   <= pc_d;
      prc_q  <= prc_d;
      npc_q  <= npc_d;
    end
  end

  // left neighbor, upper-left tap and running patch flags
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      left_q  <= vertex_hit_i;
      tail2_q <= lb_bit[LB_N-1];
      if (is_tile) begin
        acc_clr_q <= new_clr;
        acc_hit_q <= new_hit;
      end
    end
  end

  // output register with skid
  assign take = out_vld_q & ~out_stall_i;
  assign push = in_acc & is_tile;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (take) begin
          skid_vld_q <= 1'b0;
        end
      end else if (push) begin
        if (out_vld_q && !take) begin
          skid_vld_q <= 1'b1;
        end else begin
          out_vld_q <= 1'b1;
        end
      end else if (take) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_vld_q && !take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign tile_valid_o  = out_vld_q;
  assign tile_col_o    = out_q.tile_col;
  assign tile_row_o    = out_q.tile_row;
  assign tile_hit_o    = out_q.tile_hit;
  assign patch_valid_o = out_q.patch_valid;
  assign patch_col_o   = out_q.patch_col;
  assign patch_row_o   = out_q.patch_row;
  assign patch_class_o = out_q.patch_class;
  assign grid_done_o   = out_q.grid_done;

endmodule

`default_nettype wire

### hdl/gtpc_checker.sv
`default_nettype none

module gtpc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       tile_valid_o,
  input wire logic [5:0] tile_col_o,
  input wire logic [5:0] tile_row_o,
  input wire logic       tile_hit_o,
  input wire logic       patch_valid_o,
  input wire logic [5:0] patch_col_o,
  input wire logic [5:0] patch_row_o,
  input wire logic [1:0] patch_class_o,
  input wire logic       grid_done_o
);

  // the last tile of the grid always closes a patch
  a_done_closes_patch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && grid_done_o) |-> patch_valid_o)
    else $error("grid done without a finished patch");

  // patch fields stay zero when no patch finishes
  a_patch_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !patch_valid_o) |->
      (patch_col_o == 6'd0 && patch_row_o == 6'd0 &&
       patch_class_o == gtpc_pkg::PC_CLEAR))
    else $error("patch fields set without a finished patch");

  // the closing tile must agree with the patch class
  a_class_vs_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && patch_valid_o) |->
      ((tile_hit_o && patch_class_o != gtpc_pkg::PC_CLEAR) ||
       (!tile_hit_o && patch_class_o != gtpc_pkg::PC_HIT)))
    else $error("patch class contradicts its last tile");

  // a result item carries a tile
  a_tile_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> tile_valid_o)
    else $error("result item without tile flag");

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(tile_col_o) && $stable(tile_row_o)))
    else $error("stalled result item changed");

endmodule

bind grid_tile_patch_classifier gtpc_checker u_gtpc_checker (.*);

`default_nettype wire
